FILE: rtl/nfa_wa_pkg.sv
// Shared types and codes for the NFA word acceptor.
package nfa_wa_pkg;

  localparam int MAX_LIVE = 64;
  localparam int CFG_W    = 64;

  localparam logic [1:0] CMD_ADD  = 2'd0;
  localparam logic [1:0] CMD_FEED = 2'd1;
  localparam logic [1:0] CMD_END  = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] from_state;
    logic [5:0] to_state;
    logic [7:0] symbol;
  } nfa_wa_item_t;

  typedef struct packed {
    logic accepted;
    logic any_active;
  } nfa_wa_result_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic clr_step;
    logic add_rd;
    logic add_wr;
    logic scan_init;
    logic scan_step;
    logic scan_commit;
    logic word_end;
  } nfa_wa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic scan_last;
    logic res_full;
  } nfa_wa_status_t;

endpackage

FILE: rtl/nfa_wa_ctrl.sv
// Sequencer for table clearing, transition insert, symbol scan and end of word.
module nfa_wa_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  input  logic [1:0]               item_cmd,
  output logic                     item_stall,
  input  nfa_wa_pkg::nfa_wa_status_t status,
  output nfa_wa_pkg::nfa_wa_cmd_t    cmd
);
  import nfa_wa_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD_RD,
    S_ADD_WR,
    S_SCAN,
    S_COMMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  // an end-of-word request waits until the previous result is taken
  assign item_stall = (state != S_IDLE) || (status.res_full && item_cmd == CMD_END);
  assign accept     = item_valid && !item_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          case (item_cmd)
            CMD_ADD: state_next = S_ADD_RD;
            CMD_FEED: begin
              cmd.scan_init = 1'b1;
              state_next    = S_SCAN;
            end
            CMD_END: cmd.word_end = 1'b1;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_ADD_RD: begin
        cmd.add_rd = 1'b1;
        state_next = S_ADD_WR;
      end
      S_ADD_WR: begin
        cmd.add_wr = 1'b1;
        state_next = S_IDLE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.scan_commit = 1'b1;
        state_next      = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/nfa_wa_dp.sv
// Datapath: transition table memory, active set, accepting mask and result register.
module nfa_wa_dp #(
  parameter int NUM_STATES   = 64,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  nfa_wa_pkg::nfa_wa_item_t   item,
  input  logic                       cfg_we,
  input  logic [nfa_wa_pkg::CFG_W-1:0] cfg_data,
  input  nfa_wa_pkg::nfa_wa_cmd_t    cmd,
  output nfa_wa_pkg::nfa_wa_status_t status,
  output nfa_wa_pkg::nfa_wa_result_t result,
  output logic                       result_valid,
  input  logic                       result_stall
);
  import nfa_wa_pkg::*;

  localparam int LIVE  = (NUM_STATES < MAX_LIVE) ? NUM_STATES : MAX_LIVE;
  localparam int SW    = $clog2(LIVE);
  localparam int YW    = $clog2(SYMBOL_COUNT);
  localparam int AW    = SW + YW;
  localparam int DEPTH = 1 << AW;

  logic [LIVE-1:0] mem [DEPTH];
  logic [LIVE-1:0] rdata;
  logic [LIVE-1:0] wdata;
  logic [AW-1:0]   raddr;
  logic [AW-1:0]   waddr;
  logic            we;

  logic [SW-1:0]   from_idx;
  logic [SW-1:0]   to_idx;
  logic [YW-1:0]   sym_idx;
  logic            add_ok;
  logic            sym_ok;

  logic [AW-1:0]   clr_cnt;
  logic [SW-1:0]   scan_cnt;
  logic [SW-1:0]   scan_idx;
  logic            rd_pend;
  logic [LIVE-1:0] acc;
  logic [LIVE-1:0] term;
  logic [LIVE-1:0] active;
  logic [LIVE-1:0] accepting;

  logic item_from_ok;
  logic item_to_ok;
  logic item_sym_ok;

  assign item_from_ok = 32'(item.from_state) < LIVE;
  assign item_to_ok   = 32'(item.to_state) < LIVE;
  assign item_sym_ok  = 32'(item.symbol) < SYMBOL_COUNT;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      from_idx <= item.from_state[SW-1:0];
      to_idx   <= item.to_state[SW-1:0];
      sym_idx  <= item.symbol[YW-1:0];
      add_ok   <= item_from_ok && item_to_ok && item_sym_ok;
      sym_ok   <= item_sym_ok;
    end
  end

  always_comb begin
    raddr = cmd.add_rd ? {from_idx, sym_idx} : {scan_cnt, sym_idx};
    waddr = cmd.clr_step ? clr_cnt : {from_idx, sym_idx};
    wdata = cmd.clr_step ? '0 : (rdata | (LIVE'(1) << to_idx));
    we    = cmd.clr_step || (cmd.add_wr && add_ok);
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // row read for state scan_idx lands in the cycle after its address
  assign term = (rd_pend && sym_ok && active[scan_idx]) ? rdata : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt      <= '0;
      scan_cnt     <= '0;
      rd_pend      <= 1'b0;
      active       <= LIVE'(1);
      accepting    <= '0;
      result_valid <= 1'b0;
    end else begin
      rd_pend  <= cmd.scan_step;
      scan_idx <= scan_cnt;
      if (cmd.clr_step) clr_cnt <= clr_cnt + AW'(1);
      if (cmd.scan_init) begin
        scan_cnt <= '0;
        acc      <= '0;
      end else begin
        if (cmd.scan_step) scan_cnt <= scan_cnt + SW'(1);
        if (rd_pend) acc <= acc | term;
      end
      if (cmd.scan_commit) active <= acc | term;
      else if (cmd.word_end) active <= LIVE'(1);
      if (cfg_we) accepting <= cfg_data[LIVE-1:0];
      if (cmd.word_end) begin
        result_valid      <= 1'b1;
        result.accepted   <= |(active & accepting);
        result.any_active <= |active;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign status.clr_last  = clr_cnt == AW'(DEPTH - 1);
  assign status.scan_last = scan_cnt == SW'(LIVE - 1);
  assign status.res_full  = result_valid;

`ifndef SYNTHESIS
  a_end_free: assert property (@(posedge clk) disable iff (rst)
    cmd.word_end |-> !result_valid)
    else $error("word end issued while result register full");
  a_end_loads: assert property (@(posedge clk) disable iff (rst)
    cmd.word_end |=> result_valid)
    else $error("result not registered after word end");
  a_rmw_order: assert property (@(posedge clk) disable iff (rst)
    cmd.add_wr |-> $past(cmd.add_rd))
    else $error("table write without preceding row read");
  a_no_clear_overlap: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_step |-> !(cmd.add_wr || cmd.scan_step || cmd.word_end))
    else $error("table clear overlaps item work");
`endif

endmodule

FILE: rtl/nfa_word_acceptor.sv
// NFA word acceptor: top level joining controller and datapath. After reset the
// transition table is cleared one row a cycle, all 2**(clog2(min(NUM_STATES,64)) +
// clog2(SYMBOL_COUNT)) rows, with item_stall high. An add-transition item is accepted,
// its row read, then written; a feed-symbol item is accepted, the single table read
// port walks min(NUM_STATES,64) state rows one row per cycle and the new active set
// is committed; an end-of-word item is done on acceptance. One item is worked on at
// a time; the result sits in an output register; a further end-of-word request stalls
// until it is taken. The user must write the accepting-state mask over
// cfg_valid/cfg_data only while the block is idle; the block does not enforce this.
module nfa_word_acceptor #(
  parameter int NUM_STATES   = 64,
  parameter int SYMBOL_COUNT = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  nfa_wa_pkg::nfa_wa_item_t     item,
  output logic                         result_valid,
  input  logic                         result_stall,
  output nfa_wa_pkg::nfa_wa_result_t   result,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [nfa_wa_pkg::CFG_W-1:0] cfg_data
);
  import nfa_wa_pkg::*;

  nfa_wa_cmd_t    cmd;
  nfa_wa_status_t status;
  logic           cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  nfa_wa_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_cmd   (item.cmd),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  nfa_wa_dp #(
    .NUM_STATES   (NUM_STATES),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule
